@@ hw/rtl/rdsb_pkg.sv @@
// Shared constants for the RRIP dead-block / stream-bypass replacement core.
// No dependencies.
`default_nettype none
package rdsb_pkg;
    localparam logic [1:0] AGE_MAX    = 2'd3;
    localparam int         COUNT_BITS = 20;

    localparam logic [1:0] CFG_STREAM_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_DECAY_PERIOD_LOG2 = 2'd1;

    localparam logic [1:0] SIGN_ZERO = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd2;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    localparam logic [2:0] THRESHOLD_RESET = 3'd3;
    localparam logic [4:0] DECAY_RESET     = 5'd12;
endpackage
`default_nettype wire

@@ hw/rtl/rrip_dead_block_stream_bypass_core.sv @@
// RRIP replacement core with dead-block reuse counters and per-set stream bypass.
// Depends on rdsb_pkg.
`default_nettype none
// Usage
// The request channel (i_valid / o_stall) carries one transaction per victim
// request (kind 0) or access update (kind 1). The result channel
// (o_valid / i_stall) returns exactly one transaction per request, in order.
// Configuration writes use i_cfg_valid / o_cfg_ready, with register index 0
// for the stream threshold and 1 for the decay period exponent; other
// indexes are ignored. Write configuration only while the core is idle.
// Operation: at the accepting edge the set's row memory and set-history memory
// are read; on the next edge the row is modified, written back and the result
// is registered. A new request is taken only once the core is back in S_IDLE,
// after that write-back, and only if no result waits under i_stall: the single
// read-modify-write of the set row keeps one request in flight at a time.
// Reset: after i_rst_n is released the core sweeps both memories, one set a
// cycle over all NUM_SETS sets (2048 by default), holding o_stall high.
// Reuse-counter halving is applied lazily: each row carries the decay epoch
// at which it was last normalized and is shifted on its next update.
// Stall: while a result waits under i_stall, no new request is taken.
module rrip_dead_block_stream_bypass_core #(
    parameter int NUM_SETS    = 2048,
    parameter int NUM_WAYS    = 16,
    parameter int DELTA_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_kind,
    input  wire logic [10:0] i_set_index,
    input  wire logic [3:0]  i_way_index,
    input  wire logic [63:0] i_access_address,
    input  wire logic        i_was_hit,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [3:0]       o_victim_way,
    output logic             o_bypassed,
    output logic             o_set_streaming,
    output logic [1:0]       o_new_age,
    output logic             o_decayed,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [4:0]  i_cfg_data
);
    import rdsb_pkg::*;

    localparam int SW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WW    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int DW    = (DELTA_DEPTH > 1) ? $clog2(DELTA_DEPTH) : 1;
    localparam int CW    = 5;
    localparam int ROW_W = NUM_WAYS * 4 + 64;
    localparam int HIS_W = 64 + 1 + DELTA_DEPTH * 2 + DW + 1;

    typedef struct packed {
        logic [63:0]            stamp;
        logic [NUM_WAYS*2-1:0]  reuse;
        logic [NUM_WAYS*2-1:0]  age;
    } t_row;

    typedef struct packed {
        logic [63:0]              last;
        logic                     av;
        logic [DELTA_DEPTH*2-1:0] signs;
        logic [DW-1:0]            slot;
        logic                     stream;
    } t_his;

    // Reduce the set index modulo NUM_SETS by restoring subtraction.
    function automatic logic [SW-1:0] f_set_mod(input logic [10:0] v);
        logic [31:0] r;
        r = {21'd0, v};
        for (int b = 10; b >= 0; b--) begin
            if (r >= (32'(NUM_SETS) << b)) begin
                r = r - (32'(NUM_SETS) << b);
            end
        end
        return r[SW-1:0];
    endfunction

    function automatic logic [WW-1:0] f_way_mod(input logic [3:0] v);
        logic [31:0] r;
        r = {28'd0, v};
        for (int b = 3; b >= 0; b--) begin
            if (r >= (32'(NUM_WAYS) << b)) begin
                r = r - (32'(NUM_WAYS) << b);
            end
        end
        return r[WW-1:0];
    endfunction

    logic [1:0]    r_state, n_state;
    logic [SW-1:0] r_clr_idx;
    logic [2:0]    r_thresh;
    logic [4:0]    r_decay_log2;
    logic [19:0]   r_cnt, n_cnt;
    logic [63:0]   r_epoch, n_epoch;

    logic          r_kind, r_hit;
    logic [SW-1:0] r_set;
    logic [WW-1:0] r_way;
    logic [63:0]   r_addr;

    logic          r_out_valid;
    logic [3:0]    r_victim;
    logic          r_bypass, r_stream, r_dec;
    logic [1:0]    r_age;

    logic [ROW_W-1:0] r_row_mem [NUM_SETS];
    logic [HIS_W-1:0] r_his_mem [NUM_SETS];
    t_row             r_row_q;
    t_his             r_his_q;

    logic accept;
    assign o_stall     = !((r_state == S_IDLE) && (!r_out_valid || !i_stall));
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // Row modification, valid in S_EXEC when the read data has arrived.
    t_row          row_new, row_clr;
    t_his          his_new, his_clr;
    logic [3:0]    victim;
    logic          bypass, stream, dec;
    logic [1:0]    age;

    always_comb begin
        logic [63:0]   delta, ediff;
        logic [1:0]    code, sh, ru;
        logic [CW-1:0] pos, neg, nz, th;
        logic          found;
        logic [4:0]    k;
        logic [20:0]   mask;
        logic [WW-1:0] ws;

        row_clr.stamp = 64'd0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            row_clr.age[w*2 +: 2]   = AGE_MAX;
            row_clr.reuse[w*2 +: 2] = 2'd1;
        end
        his_clr = '0;

        row_new = r_row_q;
        his_new = r_his_q;
        victim  = 4'd0;
        bypass  = 1'b0;
        dec     = 1'b0;
        age     = 2'd0;
        stream  = r_his_q.stream;
        n_cnt   = r_cnt;
        n_epoch = r_epoch;
        found   = 1'b0;
        pos = '0; neg = '0; nz = '0;
        code = SIGN_ZERO; sh = 2'd0; ru = 2'd0; ediff = 64'd0;
        k = 5'd0; mask = 21'd0; ws = '0;
        delta = r_addr - r_his_q.last;
        th = {2'b00, r_thresh};

        if (!r_kind) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (!found && r_row_q.age[w*2 +: 2] == AGE_MAX) begin
                    found  = 1'b1;
                    victim = 4'(w);
                end
            end
            if (!found) begin
                // No way at the maximum age: age every way, then the first
                // way that was one below the maximum is the victim.
                for (int w = 0; w < NUM_WAYS; w++) begin
                    row_new.age[w*2 +: 2] = r_row_q.age[w*2 +: 2] + 2'd1;
                    if (!found && r_row_q.age[w*2 +: 2] == 2'd2) begin
                        found  = 1'b1;
                        victim = 4'(w);
                    end
                end
            end
        end else begin
            if (delta == 64'd0) begin
                code = SIGN_ZERO;
            end else if (delta[63]) begin
                code = SIGN_NEG;
            end else begin
                code = SIGN_POS;
            end
            if (r_his_q.av) begin
                his_new.signs[r_his_q.slot*2 +: 2] = code;
                if (32'(r_his_q.slot) == DELTA_DEPTH - 1) begin
                    his_new.slot = '0;
                end else begin
                    his_new.slot = r_his_q.slot + DW'(1);
                end
            end
            his_new.last = r_addr;
            his_new.av   = 1'b1;
            for (int i = 0; i < DELTA_DEPTH; i++) begin
                if (his_new.signs[i*2 +: 2] == SIGN_POS) pos = pos + CW'(1);
                else if (his_new.signs[i*2 +: 2] == SIGN_NEG) neg = neg + CW'(1);
                if (his_new.signs[i*2 +: 2] != SIGN_ZERO) nz = nz + CW'(1);
            end
            stream = (nz >= th) && ((pos >= th) || (neg >= th));
            his_new.stream = stream;

            n_cnt = r_cnt + 20'd1;
            k     = (r_decay_log2 > 5'(COUNT_BITS)) ? 5'(COUNT_BITS) : r_decay_log2;
            mask  = (21'd1 << k) - 21'd1;
            dec   = ((n_cnt & mask[19:0]) == 20'd0);
            n_epoch = r_epoch + {63'd0, dec};

            // Apply every halving this row has missed, then stamp it current.
            ediff = n_epoch - r_row_q.stamp;
            sh    = (ediff == 64'd0) ? 2'd0 : ((ediff == 64'd1) ? 2'd1 : 2'd2);
            for (int w = 0; w < NUM_WAYS; w++) begin
                row_new.reuse[w*2 +: 2] = r_row_q.reuse[w*2 +: 2] >> sh;
            end
            row_new.stamp = n_epoch;

            ws = r_way;
            ru = row_new.reuse[ws*2 +: 2];
            if (!r_hit && stream) begin
                age    = AGE_MAX;
                bypass = 1'b1;
                row_new.reuse[ws*2 +: 2] = 2'd0;
            end else if (r_hit) begin
                age = 2'd0;
                if (ru != 2'd3) row_new.reuse[ws*2 +: 2] = ru + 2'd1;
            end else begin
                if (ru == 2'd0) age = AGE_MAX;
                else if (ru >= 2'd2) age = 2'd0;
                else age = 2'd2;
                row_new.reuse[ws*2 +: 2] = 2'd1;
            end
            row_new.age[ws*2 +: 2] = age;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (32'(r_clr_idx) == NUM_SETS - 1) n_state = S_IDLE;
            S_IDLE:  if (accept) n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_idx    <= '0;
            r_thresh     <= THRESHOLD_RESET;
            r_decay_log2 <= DECAY_RESET;
            r_cnt        <= 20'd0;
            r_epoch      <= 64'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr_idx <= r_clr_idx + SW'(1);
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_STREAM_THRESHOLD) r_thresh <= i_cfg_data[2:0];
                else if (i_cfg_index == CFG_DECAY_PERIOD_LOG2) r_decay_log2 <= i_cfg_data;
            end
            if (r_state == S_EXEC) begin
                r_cnt       <= n_cnt;
                r_epoch     <= n_epoch;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_hit  <= i_was_hit;
            r_set  <= f_set_mod(i_set_index);
            r_way  <= f_way_mod(i_way_index);
            r_addr <= i_access_address;
        end
        if (r_state == S_EXEC) begin
            r_victim <= victim;
            r_bypass <= bypass;
            r_stream <= stream;
            r_age    <= age;
            r_dec    <= dec;
        end
    end

    // Set memories: one read port driven at accept, one write port.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row_q <= r_row_mem[f_set_mod(i_set_index)];
            r_his_q <= r_his_mem[f_set_mod(i_set_index)];
        end
        if (r_state == S_CLEAR) begin
            r_row_mem[r_clr_idx] <= row_clr;
            r_his_mem[r_clr_idx] <= his_clr;
        end else if (r_state == S_EXEC) begin
            r_row_mem[r_set] <= row_new;
            r_his_mem[r_set] <= his_new;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_victim_way    = r_victim;
    assign o_bypassed      = r_bypass;
    assign o_set_streaming = r_stream;
    assign o_new_age       = r_age;
    assign o_decayed       = r_dec;
endmodule
`default_nettype wire

@@ tb/rrip_dead_block_stream_bypass_checker.sv @@
// Checker for the RRIP dead-block / stream-bypass core: watches the request, result and
// configuration channels, keeps its own copy of the replacement state and compares results.
// Depends on rdsb_pkg.
`default_nettype none
module rrip_dead_block_stream_bypass_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_stall_req,
    input  wire logic        i_kind,
    input  wire logic [10:0] i_set_index,
    input  wire logic [3:0]  i_way_index,
    input  wire logic [63:0] i_access_address,
    input  wire logic        i_was_hit,
    input  wire logic        i_rsp_valid,
    input  wire logic        i_rsp_stall,
    input  wire logic [3:0]  i_victim_way,
    input  wire logic        i_bypassed,
    input  wire logic        i_set_streaming,
    input  wire logic [1:0]  i_new_age,
    input  wire logic        i_decayed,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [4:0]  i_cfg_data,
    output int               o_errors,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rdsb_pkg::*;

    typedef struct packed {
        logic [3:0] victim_way;
        logic       bypassed;
        logic       set_streaming;
        logic [1:0] new_age;
        logic       decayed;
    } outcome_t;

    logic [1:0]  age_mem [2048][16];
    logic [1:0]  reuse_mem [2048][16];
    logic [63:0] prev_addr [2048];
    bit          prev_seen [2048];
    logic [1:0]  signs [2048][4];
    logic [1:0]  slot [2048];
    bit          streaming [2048];
    logic [19:0] n_updates;
    logic [2:0]  threshold;
    logic [4:0]  decay_log2;
    outcome_t    expected_q[$];

    assign o_pending = expected_q.size();

    task automatic report(input string what, input int got, input int want);
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    function automatic outcome_t predict_replacement(input logic k, input logic [10:0] s,
            input logic [3:0] w, input logic [63:0] a, input logic h);
        outcome_t r;
        logic [63:0] d;
        int pos, neg, nz, lim;
        logic [19:0] mask;
        bit found;
        r = '0;
        found = 0;
        if (!k) begin
            for (int i = 0; i < 16; i++)
                if (!found && age_mem[s][i] == AGE_MAX) begin
                    r.victim_way = i[3:0];
                    found = 1;
                end
            if (!found) begin
                for (int i = 0; i < 16; i++)
                    if (age_mem[s][i] < AGE_MAX) age_mem[s][i]++;
                for (int i = 0; i < 16; i++)
                    if (!found && age_mem[s][i] == AGE_MAX) begin
                        r.victim_way = i[3:0];
                        found = 1;
                    end
            end
        end else begin
            if (prev_seen[s]) begin
                d = a - prev_addr[s];
                signs[s][slot[s]] = (d == 0) ? SIGN_ZERO : (d[63] ? SIGN_NEG : SIGN_POS);
                slot[s] = slot[s] + 2'd1;
            end
            prev_addr[s] = a;
            prev_seen[s] = 1;
            pos = 0; neg = 0; nz = 0;
            for (int i = 0; i < 4; i++) begin
                if (signs[s][i] == SIGN_POS) pos++;
                else if (signs[s][i] == SIGN_NEG) neg++;
                if (signs[s][i] != SIGN_ZERO) nz++;
            end
            streaming[s] = nz >= threshold && (pos >= threshold || neg >= threshold);
            lim = (decay_log2 > 20) ? 20 : decay_log2;
            mask = 20'((64'd1 << lim) - 1);
            n_updates = n_updates + 20'd1;
            if ((n_updates & mask) == 0) begin
                foreach (reuse_mem[i, j]) reuse_mem[i][j] = reuse_mem[i][j] >> 1;
                r.decayed = 1;
            end
            if (!h && streaming[s]) begin
                r.new_age = AGE_MAX;
                reuse_mem[s][w] = 2'd0;
                r.bypassed = 1;
            end else if (h) begin
                r.new_age = 2'd0;
                if (reuse_mem[s][w] < 2'd3) reuse_mem[s][w]++;
            end else begin
                if (reuse_mem[s][w] == 0) r.new_age = AGE_MAX;
                else if (reuse_mem[s][w] >= 2) r.new_age = 2'd0;
                else r.new_age = 2'd2;
                reuse_mem[s][w] = 2'd1;
            end
            age_mem[s][w] = r.new_age;
        end
        r.set_streaming = streaming[s];
        return r;
    endfunction

    initial begin
        o_errors = 0;
        foreach (age_mem[i, j]) begin
            age_mem[i][j] = AGE_MAX;
            reuse_mem[i][j] = 2'd1;
        end
        foreach (prev_addr[i]) begin
            prev_addr[i] = '0;
            prev_seen[i] = 0;
            slot[i] = '0;
            streaming[i] = 0;
            for (int j = 0; j < 4; j++) signs[i][j] = SIGN_ZERO;
        end
        n_updates = '0;
        threshold = THRESHOLD_RESET;
        decay_log2 = DECAY_RESET;
    end

    always @(posedge i_clk) begin
        outcome_t want;
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_STREAM_THRESHOLD) threshold = i_cfg_data[2:0];
                else if (i_cfg_index == CFG_DECAY_PERIOD_LOG2) decay_log2 = i_cfg_data;
            end
            if (i_rsp_valid && !i_rsp_stall) begin
                if (expected_q.size() == 0) begin
                    report("unexpected result", 1, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (i_victim_way !== want.victim_way)
                        report("victim_way", i_victim_way, want.victim_way);
                    if (i_bypassed !== want.bypassed)
                        report("bypassed", i_bypassed, want.bypassed);
                    if (i_set_streaming !== want.set_streaming)
                        report("set_streaming", i_set_streaming, want.set_streaming);
                    if (i_new_age !== want.new_age)
                        report("new_age", i_new_age, want.new_age);
                    if (i_decayed !== want.decayed)
                        report("decayed", i_decayed, want.decayed);
                end
            end
            if (i_valid && !i_stall_req)
                expected_q.push_back(predict_replacement(i_kind, i_set_index, i_way_index,
                    i_access_address, i_was_hit));
        end
    end
endmodule
`default_nettype wire

@@ tb/tb_rrip_dead_block_stream_bypass_core.sv @@
// Testbench top for rrip_dead_block_stream_bypass_core: drives directed and random
// victim/update transactions and configuration writes; checking is in the checker module.
// Depends on rdsb_pkg, the core and rrip_dead_block_stream_bypass_checker.
`default_nettype none
module tb_rrip_dead_block_stream_bypass_core;
    timeunit 1ns;
    timeprecision 1ps;
    import rdsb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic        kind;
    logic [10:0] set_index;
    logic [3:0]  way_index;
    logic [63:0] access_address;
    logic        was_hit;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [3:0]  victim_way;
    logic        bypassed;
    logic        set_streaming;
    logic [1:0]  new_age;
    logic        decayed;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [4:0]  cfg_data;
    int          errors;
    int          pending;
    bit          calm;       // when set, neither side inserts idle cycles

    rrip_dead_block_stream_bypass_core uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(req_valid), .o_stall(req_stall),
        .i_kind(kind), .i_set_index(set_index), .i_way_index(way_index),
        .i_access_address(access_address), .i_was_hit(was_hit),
        .o_valid(rsp_valid), .i_stall(rsp_stall),
        .o_victim_way(victim_way), .o_bypassed(bypassed),
        .o_set_streaming(set_streaming), .o_new_age(new_age), .o_decayed(decayed),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    rrip_dead_block_stream_bypass_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(req_valid), .i_stall_req(req_stall),
        .i_kind(kind), .i_set_index(set_index), .i_way_index(way_index),
        .i_access_address(access_address), .i_was_hit(was_hit),
        .i_rsp_valid(rsp_valid), .i_rsp_stall(rsp_stall),
        .i_victim_way(victim_way), .i_bypassed(bypassed),
        .i_set_streaming(set_streaming), .i_new_age(new_age), .i_decayed(decayed),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // The result side stalls at random, except during calm stretches.
    always @(posedge clk) begin
        rsp_stall <= !calm && ($urandom_range(99) < 31);
    end

    // One request transaction. Valid is held until accepted; an idle gap, when drawn,
    // comes before valid is raised, so a stalled payload never changes.
    task automatic send_request(input logic k, input logic [10:0] s, input logic [3:0] w,
            input logic [63:0] a, input logic h);
        while (!calm && $urandom_range(99) < 31) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        kind <= k;
        set_index <= s;
        way_index <= w;
        access_address <= a;
        was_hit <= h;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    // Lets every outstanding result drain before a configuration write.
    task automatic drain;
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [4:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random mix: mostly strided address runs within a few hot sets, so the stream
    // detector fills its ring and the bypass path opens, with random noise in between.
    task automatic random_phase(input int count);
        logic [10:0] s;
        logic [63:0] a;
        logic [63:0] stride;
        int run;
        run = 0;
        s = '0; a = '0; stride = '0;
        for (int n = 0; n < count; n++) begin
            if (run == 0) begin
                s = ($urandom_range(3) == 0) ? 11'($urandom) : 11'($urandom_range(7));
                a = {$urandom, $urandom};
                stride = 64'($urandom_range(4096));
                if ($urandom_range(1)) stride = -stride;
                run = $urandom_range(12, 2);
            end
            calm = (n >= 200) && (n < 260);
            if ($urandom_range(99) < 25) begin
                send_request(1'b0, s, 4'($urandom), {$urandom, $urandom}, 1'($urandom));
            end else if ($urandom_range(99) < 15) begin
                send_request(1'b1, 11'($urandom), 4'($urandom), {$urandom, $urandom},
                             1'($urandom));
            end else begin
                a = a + stride;
                send_request(1'b1, s, 4'($urandom), a, 1'($urandom));
            end
            run--;
        end
        calm = 0;
    endtask

    initial begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        kind = 1'b0;
        set_index = '0;
        way_index = '0;
        access_address = '0;
        was_hit = 1'b0;
        rsp_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        calm = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: victim on a fresh set, extreme fields, aging with no age-3 way,
        // a zero delta, both delta signs, address zero and all-ones.
        send_request(1'b0, 11'd0, 4'd0, 64'd0, 1'b0);
        send_request(1'b1, 11'd2047, 4'd15, 64'd0, 1'b1);
        send_request(1'b1, 11'd2047, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_request(1'b1, 11'd2047, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_request(1'b1, 11'd2047, 4'd0, 64'd0, 1'b0);
        for (int i = 0; i < 16; i++)
            send_request(1'b1, 11'd5, 4'(i), 64'h1000 * i, 1'b1);
        send_request(1'b0, 11'd5, 4'd0, 64'd0, 1'b0);
        send_request(1'b0, 11'd5, 4'd0, 64'd0, 1'b0);
        send_request(1'b0, 11'd2047, 4'd0, 64'd0, 1'b0);

        random_phase(300);
        write_register(CFG_STREAM_THRESHOLD, 5'd0);
        write_register(CFG_DECAY_PERIOD_LOG2, 5'd1);
        random_phase(250);
        write_register(CFG_STREAM_THRESHOLD, 5'd4);
        write_register(CFG_DECAY_PERIOD_LOG2, 5'd0);
        random_phase(250);
        write_register(CFG_STREAM_THRESHOLD, 5'd7);
        write_register(CFG_DECAY_PERIOD_LOG2, 5'd31);
        random_phase(150);
        write_register(CFG_STREAM_THRESHOLD, 5'd2);
        write_register(CFG_DECAY_PERIOD_LOG2, 5'd3);
        write_register(2'd3, 5'd9);
        random_phase(300);

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("rrip_dead_block_stream_bypass_core: match");
        else
            $display("rrip_dead_block_stream_bypass_core: mismatch");
        $finish;
    end

    initial begin
        #2000000;
        $display("rrip_dead_block_stream_bypass_core: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
